### rtl/life_generation_stream_macros.svh
// Assertion macros shared by the life generation stream RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LIFE_GENERATION_STREAM_MACROS_SVH
`define LIFE_GENERATION_STREAM_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define LGS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgs check failed");

// Next-cycle implication.
`define LGS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgs check failed");

`endif

### rtl/lgs_pkg.sv
// Shared types and constants for the life generation stream.
// No dependencies; imported by every module of the block.
package lgs_pkg;

    localparam int MAX_WIDTH = 32;                      // line buffer depth
    localparam int TAP_W     = $clog2(MAX_WIDTH);       // line tap index width

    localparam int ROWS_W    = 12;
    localparam int COL_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ROWS_W;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    localparam logic [ROWS_W-1:0] GRID_ROWS_RST = 12'd5;
    localparam logic [COL_W-1:0]  GRID_COLS_RST = 6'd4;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // One result transaction.
    typedef struct packed {
        logic next_alive;
        logic frame_last;
    } res_t;

    // Per-step control from the sequencer to the window.
    typedef struct packed {
        logic go;       // window advances this cycle
        logic first;    // column 0 of a row: older columns are dead
        logic emit_a;   // emit the cell left of the incoming column
        logic emit_b;   // row end: emit the incoming column against a dead edge
        logic mark_b;   // result b closes the frame
    } step_ctrl_t;

    // Up to two results written into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       d0;
        res_t       d1;
    } ofifo_wr_t;

endpackage

### rtl/life_generation_stream.sv
// Streaming Conway Life (B3/S23) generation engine, top level.
// Depends on lgs_pkg, lgs_linebuf, lgs_window, lgs_ofifo and the macro header.
//
// Usage:
//  - Input channel (in_valid/in_stall/cell_alive): one cell per transaction, raster
//    order, grid_cols cells per row, grid_rows rows per frame. Outside cells are dead.
//  - Output channel (out_valid/out_stall/next_alive/frame_last): next-generation
//    cells in raster order; frame_last marks the final cell of the frame.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 grid_rows,
//    index 1 grid_cols. A geometry write restarts the frame; results already queued still
//    go out. Rows of 0 act as 1; columns of 0 act as 1, above 32 act as 32.
//  - Ordering: the result for cell (r-1, c-1) is queued by the transaction of
//    cell (r, c); out_valid is decoded from the registered queue fill count.
//  - Throughput: one cell per clock while in_stall is low. After the last cell
//    of a frame the input stalls while the line buffers replay the bottom row, a step
//    per column (1 to 32, more if the queue is full); the only per-frame bubble.
//  - A four-entry result queue separates the sides; input also stalls when fewer
//    than two slots are free, so an output stall backs up into in_stall.
//  - Reset: counters cleared, queue empty, grid_rows = 5, grid_cols = 4.
`include "life_generation_stream_macros.svh"

module life_generation_stream
    import lgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cell input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cell_alive,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  next_alive,
    output logic                  frame_last,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic {
        ST_STREAM,   // taking cells
        ST_FLUSH     // replaying the last row of a frame
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ROWS_W-1:0] row_count_reg;
    logic [ROWS_W-1:0] row_count_next;
    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic              flush_top_reg;    // last row has a row above it
    logic              flush_top_next;
    logic [ROWS_W-1:0] grid_rows_reg;
    logic [ROWS_W-1:0] grid_rows_next;
    logic [COL_W-1:0]  grid_cols_reg;
    logic [COL_W-1:0]  grid_cols_next;

    logic [ROWS_W-1:0] rows_m1;
    logic [COL_W-1:0]  cols_m1;
    logic              is_flush;
    logic              room_ok;
    logic              step_go;
    logic              col_first;
    logic              col_last;
    logic              row_last;
    logic              row_ge1;
    logic              row_ge2;
    logic              mid_tap;
    logic              above_tap;
    logic              lb_mid_in;
    logic              lb_above_in;
    logic [2:0]        col_bits;
    logic              cfg_go;
    step_ctrl_t        ctrl;
    ofifo_wr_t         wr;
    res_t              head;

    // effective geometry
    always_comb
    begin
        rows_m1 = (grid_rows_reg == '0) ? '0 : grid_rows_reg - ROWS_W'(1);
        if (grid_cols_reg == '0)
            cols_m1 = '0;
        else if (grid_cols_reg > COL_W'(MAX_WIDTH))
            cols_m1 = COL_W'(MAX_WIDTH - 1);
        else
            cols_m1 = grid_cols_reg - COL_W'(1);
    end

    // step decode: a stream step per accepted cell, a flush step per replayed column
    always_comb
    begin
        is_flush  = (state_reg == ST_FLUSH);
        in_stall  = is_flush | ~room_ok;
        step_go   = is_flush ? room_ok : (in_valid & ~in_stall);
        cfg_ready = ~is_flush;
        cfg_go    = cfg_valid & cfg_ready;

        col_first = (col_count_reg == '0);
        col_last  = (col_count_reg == cols_m1);
        row_last  = (row_count_reg == rows_m1);
        row_ge1   = (row_count_reg != '0);
        row_ge2   = (row_count_reg > ROWS_W'(1));

        if (is_flush)
        begin
            // bottom edge: dead row below, buffers rotate back on themselves
            col_bits    = {1'b0, mid_tap, flush_top_reg & above_tap};
            lb_mid_in   = mid_tap;
            lb_above_in = above_tap;
        end
        else
        begin
            col_bits    = {cell_alive, row_ge1 & mid_tap, row_ge2 & above_tap};
            lb_mid_in   = cell_alive;
            lb_above_in = mid_tap;
        end

        ctrl.go     = step_go;
        ctrl.first  = col_first;
        ctrl.emit_a = (is_flush | row_ge1) & ~col_first;
        ctrl.emit_b = (is_flush | row_ge1) & col_last;
        ctrl.mark_b = is_flush & col_last;
    end

    // sequencer and config registers
    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        flush_top_next = flush_top_reg;
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;

        if (cfg_go)
        begin
            case (cfg_index)
                REG_GRID_ROWS:
                begin
                    grid_rows_next = cfg_data[ROWS_W-1:0];
                    row_count_next = '0;
                    col_count_next = '0;
                end
                REG_GRID_COLS:
                begin
                    grid_cols_next = cfg_data[COL_W-1:0];
                    row_count_next = '0;
                    col_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (step_go)
        begin
            if (!col_last)
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
            else
            begin
                col_count_next = '0;
                if (is_flush)
                begin
                    state_next = ST_STREAM;
                end
                else if (row_last)
                begin
                    row_count_next = '0;
                    flush_top_next = row_ge1;
                    state_next     = ST_FLUSH;
                end
                else
                begin
                    row_count_next = row_count_reg + ROWS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_STREAM;
            row_count_reg <= '0;
            col_count_reg <= '0;
            flush_top_reg <= 1'b0;
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            flush_top_reg <= flush_top_next;
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    lgs_linebuf u_linebuf (
        .clk       (clk),
        .shift     (step_go),
        .mid_in    (lb_mid_in),
        .above_in  (lb_above_in),
        .tap_idx   (cols_m1[TAP_W-1:0]),
        .mid_tap   (mid_tap),
        .above_tap (above_tap)
    );

    lgs_window u_window (
        .clk    (clk),
        .ctrl   (ctrl),
        .col_in (col_bits),
        .wr     (wr)
    );

    lgs_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .room_ok   (room_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head)
    );

    assign next_alive = head.next_alive;
    assign frame_last = head.frame_last;

    // last cell of a frame starts the bottom-row replay unless a register write is accepted with it
    `LGS_ASSERT_NEXT(a_last_cell_flushes, !is_flush && step_go && !cfg_go && col_last && row_last, state_reg == ST_FLUSH)
    // replay ends back at the frame origin
    `LGS_ASSERT_NEXT(a_flush_exit_origin, is_flush && step_go && col_last, state_reg == ST_STREAM && row_count_reg == '0 && col_count_reg == '0)
    // column and row counters stay within the effective grid
    `LGS_ASSERT_IMPL(a_col_in_range, 1'b1, col_count_reg <= cols_m1 && row_count_reg <= rows_m1)

endmodule

### rtl/lgs_cell.sv
// One column slot of the line buffers: middle-row and upper-row bits.
// Depends on lgs_pkg; chained by lgs_linebuf.
module lgs_cell
    import lgs_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  logic mid_in,
    input  logic above_in,
    output logic mid_out,
    output logic above_out
);

    logic mid_reg;
    logic above_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            mid_reg   <= mid_in;
            above_reg <= above_in;
        end
    end

    assign mid_out   = mid_reg;
    assign above_out = above_reg;

endmodule

### rtl/lgs_linebuf.sv
// Two line buffers as a chain of lgs_cell slots with a tap at the row length.
// Depends on lgs_pkg and lgs_cell.
module lgs_linebuf
    import lgs_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic             mid_in,
    input  logic             above_in,
    input  logic [TAP_W-1:0] tap_idx,
    output logic             mid_tap,
    output logic             above_tap
);

    logic mid_q   [MAX_WIDTH];
    logic above_q [MAX_WIDTH];

    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            lgs_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .mid_in    (mid_in),
                .above_in  (above_in),
                .mid_out   (mid_q[k]),
                .above_out (above_q[k])
            );
        end
        else
        begin : g_body
            lgs_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .mid_in    (mid_q[k-1]),
                .above_in  (above_q[k-1]),
                .mid_out   (mid_q[k]),
                .above_out (above_q[k])
            );
        end
    end

    // slot cols-1 holds the entry written one row ago
    assign mid_tap   = mid_q[tap_idx];
    assign above_tap = above_q[tap_idx];

endmodule

### rtl/lgs_window.sv
// 3x3 window: two stored columns plus the incoming one, and the B3/S23 rule.
// Depends on lgs_pkg.
module lgs_window
    import lgs_pkg::*;
(
    input  logic       clk,
    input  step_ctrl_t ctrl,
    input  logic [2:0] col_in,   // bit 0 upper, bit 1 middle, bit 2 lower
    output ofifo_wr_t  wr
);

    logic [2:0] prev1_reg;
    logic [2:0] prev2_reg;
    logic [2:0] p1_eff;
    logic [2:0] p2_eff;
    logic       res_a;
    logic       res_b;
    logic       do_a;
    logic       do_b;

    // window bit 4 is the center cell
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                n = n + {3'b000, win[i]};
            end
        end
        return (n == 4'd3) || (win[4] && (n == 4'd2));
    endfunction

    always_comb
    begin
        p1_eff = ctrl.first ? 3'b000 : prev1_reg;
        p2_eff = ctrl.first ? 3'b000 : prev2_reg;
        res_a  = life_rule({col_in, p1_eff, p2_eff});
        res_b  = life_rule({3'b000, col_in, p1_eff});
        do_a   = ctrl.go & ctrl.emit_a;
        do_b   = ctrl.go & ctrl.emit_b;

        wr.cnt           = 2'(do_a) + 2'(do_b);
        wr.d1.next_alive = res_b;
        wr.d1.frame_last = ctrl.mark_b;
        if (do_a)
        begin
            wr.d0.next_alive = res_a;
            wr.d0.frame_last = 1'b0;
        end
        else
        begin
            wr.d0 = wr.d1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            prev1_reg <= col_in;
            prev2_reg <= p1_eff;
        end
    end

endmodule

### rtl/lgs_ofifo.sv
// Four-entry result queue: up to two writes and one read per cycle.
// Depends on lgs_pkg.
module lgs_ofifo
    import lgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ofifo_wr_t wr,
    output logic      room_ok,    // space for two results
    output logic      out_valid,
    input  logic      out_stall,
    output res_t      out_data
);

    res_t                   mem_reg [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0] wr_ptr_next;
    logic [OFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OFIFO_PTR_W-1:0] rd_ptr_next;
    logic [OFIFO_CNT_W-1:0] count_reg;
    logic [OFIFO_CNT_W-1:0] count_next;
    logic                   rd;

    always_comb
    begin
        rd          = out_valid & ~out_stall;
        wr_ptr_next = wr_ptr_reg + OFIFO_PTR_W'(wr.cnt);
        rd_ptr_next = rd_ptr_reg + OFIFO_PTR_W'(rd);
        count_next  = count_reg + OFIFO_CNT_W'(wr.cnt) - OFIFO_CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr.d0;
        end
        if (wr.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + OFIFO_PTR_W'(1)] <= wr.d1;
        end
    end

    assign room_ok   = count_reg <= OFIFO_CNT_W'(OFIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];

endmodule

### test/life_generation_stream_test.sv
// Self-checking testbench for life_generation_stream: a directed plan, then random frames.
// Depends on lgs_pkg and the life_generation_stream RTL; an in-bench predictor checks results.
module life_generation_stream_test;
    import lgs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;   // watchdog, far above the slowest legal run
    localparam int SETTLE       = 48;       // covers the bottom-row replay
    localparam int LONG_HOLD    = 300;      // receiver hold-off that backs up into in_stall
    localparam int RANDOM_CELLS = 420;
    localparam int MAX_SHOWN    = 10;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum logic {ROW_CFG, ROW_CELL} plan_kind_e;

    // One row of the directed plan: a register write or one cell transaction.
    // For cells, data[0] is the cell; typed rows force next_alive of every result they cause.
    typedef struct packed {
        plan_kind_e              kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    typed;
        logic                    typed_val;
    } plan_row_t;

    localparam int PLAN_LEN = 31;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // reset geometry 5x4: dead row 0 (no results), then dead row 1 (all results dead)
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b1, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b1, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b1, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b1, 1'b0},
        // zero rows and zero columns both act as one: a lone cell always dies
        '{ROW_CFG,  REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_GRID_COLS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b1, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b1, 1'b0},
        // 3x3 vertical blinker, with ignored writes to spare indexes mid-frame
        '{ROW_CFG,  REG_GRID_ROWS, 12'd3, 1'b0, 1'b0},
        '{ROW_CFG,  REG_GRID_COLS, 12'd3, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_SPARE_2,   12'hFFF, 1'b0, 1'b0},
        '{ROW_CFG,  REG_SPARE_3,   12'h5A5, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd0, 1'b0, 1'b0},
        // tallest grid, one column wide, all alive
        '{ROW_CFG,  REG_GRID_ROWS, 12'hFFF, 1'b0, 1'b0},
        '{ROW_CFG,  REG_GRID_COLS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0},
        '{ROW_CELL, REG_GRID_ROWS, 12'd1, 1'b0, 1'b0}
    };

    // DUT ports; every input has a known value from time zero.
    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  cell_alive = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  next_alive;
    logic                  frame_last;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    life_generation_stream uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_alive (cell_alive),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: two previous rows, 3x3 window, raster position
    // and the geometry registers as last written.
    // ---------------------------------------------------------------
    logic              prev2_row [MAX_WIDTH] = '{default: 1'b0};  // row two back
    logic              prev1_row [MAX_WIDTH] = '{default: 1'b0};  // row one back
    logic [8:0]        win3x3   = '0;     // 3 columns x {top, mid, bottom}, oldest in [2:0]
    logic [ROWS_W-1:0] cur_row  = '0;
    logic [COL_W-1:0]  cur_col  = '0;
    logic [ROWS_W-1:0] rows_set = GRID_ROWS_RST;
    logic [COL_W-1:0]  cols_set = GRID_COLS_RST;

    res_t       next_gen_q [$];           // expected result transactions, oldest first
    int         mismatches    = 0;
    int         cycles        = 0;
    int         hold_requests = 0;        // bumped by the main flow to ask for a long hold-off
    idle_mode_e idle_mode     = IDLE_NONE;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void flag(string msg);
        if (mismatches < MAX_SHOWN)
            $display("%s", msg);
        mismatches++;
    endfunction

    // New column enters at the top of the window: bit 0 top, bit 1 mid, bit 2 bottom.
    function automatic void shift_in_col(logic top, logic mid, logic bot);
        win3x3 = {bot, mid, top, win3x3[8:3]};
    endfunction

    // B3/S23 on the window center.
    function automatic logic life_rule();
        int n = 0;
        for (int i = 0; i < 9; i++)
            if (i != 4)
                n += win3x3[i];
        return (n == 3) || (win3x3[4] && n == 2);
    endfunction

    function automatic void queue_cell(logic closes_frame);
        res_t item;
        item.next_alive = life_rule();
        item.frame_last = closes_frame;
        next_gen_q.push_back(item);
    endfunction

    // Advance the predictor by one accepted cell and queue every result it causes.
    // The final cell of a frame also replays the line buffers for the bottom row.
    function automatic void predict_next_gen(logic cell_val);
        int unsigned nrows, ncols, r, c;
        logic        top, mid;
        bit          last;
        nrows = (rows_set == 0) ? 1 : int'(rows_set);
        ncols = (cols_set == 0) ? 1 : ((cols_set > MAX_WIDTH) ? MAX_WIDTH : int'(cols_set));
        r = cur_row;
        c = cur_col;
        if (r >= nrows || c >= ncols) begin
            r = 0;
            c = 0;
        end
        if (c == 0)
            win3x3 = '0;
        top = (r >= 2) ? prev2_row[c] : 1'b0;
        mid = (r >= 1) ? prev1_row[c] : 1'b0;
        prev2_row[c] = prev1_row[c];
        prev1_row[c] = cell_val;
        shift_in_col(top, mid, cell_val);
        if (r >= 1) begin
            if (c >= 1)
                queue_cell(1'b0);
            if (c == ncols - 1) begin
                shift_in_col(1'b0, 1'b0, 1'b0);   // dead right edge
                queue_cell(1'b0);
            end
        end
        last = (r == nrows - 1) && (c == ncols - 1);
        if (last) begin
            // bottom row: row above from prev2, bottom row itself from prev1, dead below
            win3x3 = '0;
            for (int unsigned j = 0; j < ncols; j++) begin
                shift_in_col((r >= 1) ? prev2_row[j] : 1'b0, prev1_row[j], 1'b0);
                if (j >= 1)
                    queue_cell(1'b0);
            end
            shift_in_col(1'b0, 1'b0, 1'b0);
            queue_cell(1'b1);
        end
        if (c == ncols - 1) begin
            c = 0;
            r = last ? 0 : r + 1;
        end else begin
            c++;
        end
        cur_row = ROWS_W'(r);
        cur_col = COL_W'(c);
    endfunction

    function automatic bit sender_rests();
        return (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 54) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8);
    endfunction

    function automatic bit receiver_rests();
        return (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 54) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8);
    endfunction

    // Drain: every expected result back, then enough cycles for any replay to finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (next_gen_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write transaction; a geometry write restarts the frame.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GRID_ROWS: rows_set = data[ROWS_W-1:0];
            REG_GRID_COLS: cols_set = data[COL_W-1:0];
            default: ;
        endcase
        if (idx == REG_GRID_ROWS || idx == REG_GRID_COLS) begin
            cur_row = '0;
            cur_col = '0;
            win3x3  = '0;
        end
        cfg_valid <= 1'b0;
    endtask

    // One cell transaction. valid is only lowered for a gap, so back-to-back
    // transactions keep it high without a second assignment in the same step.
    task automatic send_cell(input logic cell_val, input logic typed, input logic typed_val);
        int   base;
        res_t item;
        while (sender_rests()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_alive <= cell_val;
        do @(posedge clk); while (in_stall);
        base = next_gen_q.size();
        predict_next_gen(cell_val);
        if (typed) begin
            for (int k = base; k < next_gen_q.size(); k++) begin
                item = next_gen_q[k];
                item.next_alive = typed_val;
                next_gen_q[k] = item;
            end
        end
    endtask

    // Receiver: checks each accepted result against the oldest expectation and
    // picks the next cycle's stall. A pending hold-off request starts a LONG_HOLD hold-off.
    initial begin
        int   hold_left;
        int   hold_seen;
        res_t want;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (next_gen_q.size() == 0) begin
                    flag($sformatf("unexpected result: next_alive=%0b frame_last=%0b",
                                   next_alive, frame_last));
                end else begin
                    want = next_gen_q.pop_front();
                    if (want.next_alive !== next_alive || want.frame_last !== frame_last)
                        flag($sformatf({"result mismatch: next_alive exp %0b got %0b,",
                                        " frame_last exp %0b got %0b"},
                                       want.next_alive, next_alive,
                                       want.frame_last, frame_last));
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= receiver_rests();
            end
        end
    end

    // Watchdog: a run that reaches the limit has hung somewhere.
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Main flow: reset, directed plan, then random phases that rotate through
    // the idling modes with a fresh geometry each phase.
    initial begin
        int unsigned       sent;
        int unsigned       items;
        int unsigned       nrows;
        int unsigned       ncols;
        int unsigned       dens;
        int unsigned       phase;
        int unsigned       sel;
        logic [ROWS_W-1:0] rows_w;
        logic [COL_W-1:0]  cols_w;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan, no idling; register writes only with the block drained
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end else begin
                send_cell(PLAN[i].data[0], PLAN[i].typed, PLAN[i].typed_val);
            end
        end

        sent  = 0;
        phase = 0;
        // always reach the hold-off and the mid-frame pause phases
        while (sent < RANDOM_CELLS || phase < 6) begin
            wait_idle();
            idle_mode = idle_mode_e'(phase % 4);

            // mostly small grids; now and then the widest, saturating or tallest ones
            sel = $urandom_range(0, 19);
            case (sel)
                0: begin
                    rows_w = ROWS_W'(2);                 // bottom row spills past the queue
                    cols_w = COL_W'(MAX_WIDTH);
                end
                1: begin
                    rows_w = ROWS_W'($urandom_range(1, 3));
                    cols_w = COL_W'($urandom_range(MAX_WIDTH + 1, 63));  // saturates
                end
                2: begin
                    rows_w = '1;                         // tallest: never finishes the frame
                    cols_w = COL_W'($urandom_range(1, 4));
                end
                3: begin
                    rows_w = '0;
                    cols_w = COL_W'($urandom_range(1, 8));
                end
                4: begin
                    rows_w = ROWS_W'($urandom_range(1, 5));
                    cols_w = '0;
                end
                default: begin
                    rows_w = ROWS_W'($urandom_range(1, 6));
                    cols_w = COL_W'($urandom_range(1, 8));
                end
            endcase
            if (phase == 4) begin
                rows_w = ROWS_W'(6);
                cols_w = COL_W'(8);
            end

            // upper data bits of a column write are junk and must be dropped
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_GRID_ROWS, rows_w);
                wait_idle();
                write_reg(REG_GRID_COLS, {(CFG_DATA_W - COL_W)'($urandom()), cols_w});
            end else begin
                write_reg(REG_GRID_COLS, {(CFG_DATA_W - COL_W)'($urandom()), cols_w});
                wait_idle();
                write_reg(REG_GRID_ROWS, rows_w);
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom()));
            end

            nrows = (rows_w == 0) ? 1 : int'(rows_w);
            ncols = (cols_w == 0) ? 1 : ((cols_w > MAX_WIDTH) ? MAX_WIDTH : int'(cols_w));
            if (rows_w == '1)
                items = $urandom_range(20, 60);
            else if (ncols == MAX_WIDTH)
                items = nrows * ncols;
            else
                items = nrows * ncols * $urandom_range(1, 3);
            // some frames are cut short and abandoned by the next geometry write
            if (phase != 4 && items > 1 && $urandom_range(0, 7) == 0)
                items = $urandom_range(1, items - 1);
            dens = $urandom_range(0, 10) * 10;

            // receiver goes quiet while cells keep coming, so the queue fills
            if (phase == 4)
                hold_requests++;

            for (int unsigned k = 0; k < items; k++) begin
                // sender pauses mid-frame until every result so far is back
                if (phase == 5 && k == items / 2) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (next_gen_q.size() != 0)
                        @(posedge clk);
                end
                send_cell($urandom_range(0, 99) < dens, 1'b0, 1'b0);
            end
            sent += items;
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_cell.sv
rtl/lgs_linebuf.sv
rtl/lgs_window.sv
rtl/lgs_ofifo.sv
rtl/life_generation_stream.sv
test/life_generation_stream_test.sv
